// ----- design/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and helpers for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAG = 3'd4,
    OP_CMP = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } sat_t;

  function automatic sat_t sat32(input logic neg, input logic [63:0] mag);
    sat_t r;
    logic [63:0] m;
    r.sat = 1'b0;
    m = 64'd0 - mag;
    if (!neg && mag > 64'h7FFF_FFFF) begin
      r.val = 32'h7FFF_FFFF;
      r.sat = 1'b1;
    end else if (neg && mag > 64'h8000_0000) begin
      r.val = 32'h8000_0000;
      r.sat = 1'b1;
    end else if (neg) begin
      r.val = m[31:0];
    end else begin
      r.val = mag[31:0];
    end
    return r;
  endfunction

endpackage

// ----- design/complex_arithmetic_unit_core.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Pipelined complex ALU on signed fixed point operands.
// ----------------------------------------------------------------------------
// Each input beat carries an operation code and two complex operands A and B.
// Each accepted beat gives exactly one output beat with the real and
// imaginary result, the compare flag and a status code.
// Stages: input register, six 32x32 multipliers, the sums and magnitudes,
// then 32 stages that each resolve one quotient bit of both divides and one
// root bit of the magnitude, and the saturating output register.
// One beat is taken in every cycle while the pipeline is not held by a
// stalled receiver; every operation uses the same path length, which the
// quotient and root stages set.
// Each stage holds its beat while the next one is full and stalled, so a
// stalled receiver fills empty stages first and only then holds in_tready
// low. No beat is lost or repeated.
// Reset empties the pipeline; no other state exists.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation[2:0], a_re[34:3], a_im[66:35], b_re[98:67], b_im[130:99]
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // res_re[31:0], res_im[63:32], equal[64], status[66:65]
  output logic [71:0]  out_tdata
);

  localparam int NIT = 32;

  typedef struct packed {
    op_t         op;
    logic        eq;
    logic        dz;
    logic        nre;
    logic        nim;
    logic        ovf_re;
    logic        ovf_im;
    logic [63:0] mre;
    logic [63:0] mim;
    logic [63:0] den;
    logic [63:0] s;
    logic [63:0] rre;
    logic [63:0] rim;
    logic [31:0] xre;
    logic [31:0] xim;
    logic [31:0] qre;
    logic [31:0] qim;
    logic [31:0] root;
    logic [33:0] srem;
  } it_t;

  function automatic void div_bit(input logic [63:0] rem, input logic [63:0] den,
                                  input logic nb, output logic [63:0] rn,
                                  output logic qb);
    logic [64:0] r2;
    logic [64:0] d;
    r2 = {rem, nb};
    d  = r2 - {1'b0, den};
    if (r2 >= {1'b0, den}) begin
      rn = d[63:0];
      qb = 1'b1;
    end else begin
      rn = r2[63:0];
      qb = 1'b0;
    end
  endfunction

  function automatic it_t it_step(input it_t x);
    it_t y;
    logic [63:0] rn;
    logic qb;
    logic [35:0] r4;
    logic [35:0] t;
    logic [35:0] d;
    y = x;
    div_bit(x.rre, x.den, x.xre[31], rn, qb);
    y.rre = rn;
    y.qre = {x.qre[30:0], qb};
    div_bit(x.rim, x.den, x.xim[31], rn, qb);
    y.rim = rn;
    y.qim = {x.qim[30:0], qb};
    y.xre = {x.xre[30:0], 1'b0};
    y.xim = {x.xim[30:0], 1'b0};
    r4 = {x.srem, x.s[63:62]};
    t  = {2'b00, x.root, 2'b01};
    d  = r4 - t;
    if (r4 >= t) begin
      y.srem = d[33:0];
      y.root = {x.root[30:0], 1'b1};
    end else begin
      y.srem = r4[33:0];
      y.root = {x.root[30:0], 1'b0};
    end
    y.s = {x.s[61:0], 2'b00};
    return y;
  endfunction

  // Stage 1: input register.
  logic        v1_r;
  op_t         op1_r;
  logic signed [31:0] ar1_r, ai1_r, br1_r, bi1_r;

  // Stage 2: products.
  logic        v2_r;
  op_t         op2_r;
  logic        eq2_r, dz2_r;
  logic signed [32:0] sre2_r, sim2_r;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;

  // Stage 3 onward: iteration stages.
  logic        vit_r [NIT+1];
  it_t         it_r  [NIT+1];

  logic        vo_r;
  logic [66:0] od_r;

  logic        en_out;
  logic        en_it [NIT+1];
  logic        en2, en1, en3;

  always_comb begin
    en_out = !vo_r || out_tready;
    en_it[NIT] = !vit_r[NIT] || en_out;
    for (int k = NIT - 1; k >= 0; k--) begin
      en_it[k] = !vit_r[k] || en_it[k+1];
    end
    en3 = en_it[0];
    en2 = !v2_r || en3;
    en1 = !v1_r || en2;
  end

  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_tvalid;
    end
    if (en1) begin
      op1_r <= op_t'(in_tdata[2:0]);
      ar1_r <= in_tdata[34:3];
      ai1_r <= in_tdata[66:35];
      br1_r <= in_tdata[98:67];
      bi1_r <= in_tdata[130:99];
    end
  end

  logic signed [31:0] m4a, m4b, m5a, m5b;

  always_comb begin
    if (op1_r == OP_MAG) begin
      m4a = ar1_r;
      m4b = ar1_r;
      m5a = ai1_r;
      m5b = ai1_r;
    end else begin
      m4a = br1_r;
      m4b = br1_r;
      m5a = bi1_r;
      m5b = bi1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
    if (en2) begin
      op2_r  <= op1_r;
      eq2_r  <= (op1_r == OP_CMP) && (ar1_r == br1_r) && (ai1_r == bi1_r);
      dz2_r  <= (br1_r == 32'sd0) && (bi1_r == 32'sd0);
      if (op1_r == OP_SUB) begin
        sre2_r <= 33'(ar1_r) - 33'(br1_r);
        sim2_r <= 33'(ai1_r) - 33'(bi1_r);
      end else begin
        sre2_r <= 33'(ar1_r) + 33'(br1_r);
        sim2_r <= 33'(ai1_r) + 33'(bi1_r);
      end
      p0_r <= ar1_r * br1_r;
      p1_r <= ai1_r * bi1_r;
      p2_r <= ar1_r * bi1_r;
      p3_r <= ai1_r * br1_r;
      p4_r <= m4a * m4b;
      p5_r <= m5a * m5b;
    end
  end

  logic signed [64:0] are3, aim3;
  logic [64:0] abs_re, abs_im;
  logic [63:0] den3;
  logic [95:0] xwre, xwim;
  it_t         it0;

  always_comb begin
    case (op2_r)
      OP_ADD, OP_SUB: begin
        are3 = 65'(sre2_r);
        aim3 = 65'(sim2_r);
      end
      OP_MUL: begin
        are3 = 65'(p0_r) - 65'(p1_r);
        aim3 = 65'(p2_r) + 65'(p3_r);
      end
      OP_DIV: begin
        are3 = 65'(p0_r) + 65'(p1_r);
        aim3 = 65'(p3_r) - 65'(p2_r);
      end
      default: begin
        are3 = 65'sd0;
        aim3 = 65'sd0;
      end
    endcase
    abs_re = are3[64] ? 65'd0 - are3 : are3;
    abs_im = aim3[64] ? 65'd0 - aim3 : aim3;
    den3   = p4_r[63:0] + p5_r[63:0];
    xwre   = {32'd0, abs_re[63:0]} << FRAC_BITS;
    xwim   = {32'd0, abs_im[63:0]} << FRAC_BITS;

    it0        = '0;
    it0.op     = op2_r;
    it0.eq     = eq2_r;
    it0.dz     = dz2_r;
    it0.nre    = are3[64];
    it0.nim    = aim3[64];
    if (op2_r == OP_MUL) begin
      it0.mre = abs_re[63:0] >> FRAC_BITS;
      it0.mim = abs_im[63:0] >> FRAC_BITS;
    end else begin
      it0.mre = abs_re[63:0];
      it0.mim = abs_im[63:0];
    end
    it0.den    = den3;
    it0.s      = den3;
    it0.ovf_re = xwre >= {den3, 32'd0};
    it0.ovf_im = xwim >= {den3, 32'd0};
    it0.rre    = xwre[95:32];
    it0.rim    = xwim[95:32];
    it0.xre    = xwre[31:0];
    it0.xim    = xwim[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vit_r[0] <= 1'b0;
    end else if (en_it[0]) begin
      vit_r[0] <= v2_r;
    end
    if (en_it[0]) begin
      it_r[0] <= it0;
    end
  end

  for (genvar k = 1; k <= NIT; k++) begin : g_it
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vit_r[k] <= 1'b0;
      end else if (en_it[k]) begin
        vit_r[k] <= vit_r[k-1];
      end
      if (en_it[k]) begin
        it_r[k] <= it_step(it_r[k-1]);
      end
    end
  end

  it_t         fz;
  sat_t        sre, sim;
  logic [63:0] fmre, fmim;
  logic [66:0] od_nxt;

  always_comb begin
    fz   = it_r[NIT];
    fmre = fz.ovf_re ? 64'h2_0000_0000 : {32'd0, fz.qre};
    fmim = fz.ovf_im ? 64'h2_0000_0000 : {32'd0, fz.qim};
    od_nxt = '0;
    case (fz.op)
      OP_ADD, OP_SUB, OP_MUL: begin
        sre = sat32(fz.nre, fz.mre);
        sim = sat32(fz.nim, fz.mim);
      end
      OP_DIV: begin
        sre = sat32(fz.nre, fmre);
        sim = sat32(fz.nim, fmim);
      end
      OP_MAG: begin
        sre = sat32(1'b0, {32'd0, fz.root});
        sim = '0;
      end
      default: begin
        sre = '0;
        sim = '0;
      end
    endcase
    case (fz.op)
      OP_ADD, OP_SUB, OP_MUL, OP_MAG: begin
        od_nxt[31:0]  = sre.val;
        od_nxt[63:32] = sim.val;
        od_nxt[66:65] = (sre.sat || sim.sat) ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        if (fz.dz) begin
          od_nxt[66:65] = ST_DZ;
        end else begin
          od_nxt[31:0]  = sre.val;
          od_nxt[63:32] = sim.val;
          od_nxt[66:65] = (sre.sat || sim.sat) ? ST_SAT : ST_OK;
        end
      end
      OP_CMP: begin
        od_nxt[64] = fz.eq;
      end
      default: begin
        od_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en_out) begin
      vo_r <= vit_r[NIT];
    end
    if (en_out) begin
      od_r <= od_nxt;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {5'd0, od_r};

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the complex arithmetic unit core.
// ----------------------------------------------------------------------------
// Directed beats cover every operation, the operand extremes, saturation,
// division by zero and the unused codes; random beats follow under several
// idling patterns. A golden function predicts each result and a checker
// compares output beats in order against the queue of predictions.
// ----------------------------------------------------------------------------
module testbench;
  import cau_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 40;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic        equal;
    logic [31:0] res_im;
    logic [31:0] res_re;
  } alu_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;

  alu_result_t pending_results[$];
  int          mismatches;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;

  complex_arithmetic_unit_core #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [63:0] abs64(input logic signed [63:0] p);
    return p[63] ? -p : p;
  endfunction

  // Exact signed sum of two values of at most 2^62 in magnitude.
  function automatic logic [63:0] signed_sum(input logic signed [63:0] p,
                                             input logic signed [63:0] q,
                                             output logic neg);
    logic [63:0] mp;
    logic [63:0] mq;
    mp = abs64(p);
    mq = abs64(q);
    if (p[63] == q[63]) begin
      neg = p[63];
      return mp + mq;
    end
    if (mp >= mq) begin
      neg = p[63];
      return mp - mq;
    end
    neg = q[63];
    return mq - mp;
  endfunction

  function automatic logic [31:0] clamp32(input logic neg, input logic [63:0] mag,
                                          inout logic sat);
    if (!neg && mag > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (neg && mag > 64'h8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return neg ? 32'(-mag) : mag[31:0];
  endfunction

  function automatic logic [63:0] fixed_quotient(input logic [63:0] mag,
                                                 input logic [63:0] den);
    logic [127:0] q;
    q = ({64'd0, mag} << FRAC) / {64'd0, den};
    return (q > 128'h2_0000_0000) ? 64'h2_0000_0000 : q[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic alu_result_t compute_result(input logic [2:0] op,
                                                 input logic signed [31:0] ar,
                                                 input logic signed [31:0] ai,
                                                 input logic signed [31:0] br,
                                                 input logic signed [31:0] bi);
    alu_result_t r;
    logic sat;
    logic nr;
    logic ni;
    logic [63:0] mr;
    logic [63:0] mi;
    logic [63:0] den;
    logic signed [63:0] xr;
    logic signed [63:0] xi;
    logic signed [63:0] yr;
    logic signed [63:0] yi;
    r = '0;
    sat = 1'b0;
    xr = ar;
    xi = ai;
    yr = br;
    yi = bi;
    case (op)
      OP_ADD: begin
        mr = signed_sum(xr, yr, nr);
        mi = signed_sum(xi, yi, ni);
        r.res_re = clamp32(nr, mr, sat);
        r.res_im = clamp32(ni, mi, sat);
      end
      OP_SUB: begin
        mr = signed_sum(xr, -yr, nr);
        mi = signed_sum(xi, -yi, ni);
        r.res_re = clamp32(nr, mr, sat);
        r.res_im = clamp32(ni, mi, sat);
      end
      OP_MUL: begin
        mr = signed_sum(xr * yr, -(xi * yi), nr);
        mi = signed_sum(xr * yi, xi * yr, ni);
        r.res_re = clamp32(nr, mr >> FRAC, sat);
        r.res_im = clamp32(ni, mi >> FRAC, sat);
      end
      OP_DIV: begin
        if (br == 0 && bi == 0) begin
          r.status = ST_DZ;
        end else begin
          den = (yr * yr) + (yi * yi);
          mr = signed_sum(xr * yr, xi * yi, nr);
          mi = signed_sum(xi * yr, -(xr * yi), ni);
          r.res_re = clamp32(nr, fixed_quotient(mr, den), sat);
          r.res_im = clamp32(ni, fixed_quotient(mi, den), sat);
        end
      end
      OP_MAG: begin
        r.res_re = clamp32(1'b0, int_sqrt((xr * xr) + (xi * xi)), sat);
      end
      OP_CMP: begin
        r.equal = (ar == br && ai == bi);
      end
      default: begin
      end
    endcase
    if (sat) r.status = ST_SAT;
    return r;
  endfunction

  task automatic send_beat(input logic [2:0] op, input logic [31:0] ar,
                           input logic [31:0] ai, input logic [31:0] br,
                           input logic [31:0] bi);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {5'd0, bi, br, ai, ar, op};
    in_tvalid <= 1'b1;
    pending_results.push_back(compute_result(op, ar, ai, br, bi));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] random_operand();
    case ($urandom_range(5, 0))
      0: return 32'h7FFF_FFFF - $urandom_range(3, 0);
      1: return 32'h8000_0000 + $urandom_range(3, 0);
      2: return $urandom_range(8, 0) - 4;
      3: return 32'($signed($urandom_range(20'hFFFFF, 0)) - 32'sh80000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [2:0] op;
    logic [31:0] ar;
    logic [31:0] ai;
    logic [31:0] br;
    logic [31:0] bi;
    for (int n = 0; n < count; n++) begin
      op = 3'($urandom_range(7, 0));
      ar = random_operand();
      ai = random_operand();
      br = random_operand();
      bi = random_operand();
      if (op == OP_CMP && $urandom_range(1, 0)) begin
        br = ar;
        bi = ai;
      end
      if (op == OP_DIV && $urandom_range(9, 0) == 0) begin
        br = 0;
        bi = 0;
      end
      send_beat(op, ar, ai, br, bi);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_basic_ops();
    for (int k = 0; k < 8; k++) begin
      send_beat(k[2:0], 32'h0003_0000, 32'hFFFE_0000, 32'h0001_8000, 32'h0002_0000);
    end
  endtask

  task automatic test_extremes();
    send_beat(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    send_beat(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_beat(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_beat(OP_MAG, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_CMP, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
    send_beat(OP_CMP, 32'h0, 32'h0, 32'h0, 32'h1);
    send_beat(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(3'd7, 32'h0, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    send_random(count);
  endtask

  always @(posedge clk) begin
    alu_result_t got;
    alu_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[66:0];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output beat %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: re %h/%h im %h/%h eq %b/%b st %0d/%0d (exp/got)",
                     want.res_re, got.res_re, want.res_im, got.res_im,
                     want.equal, got.equal, want.status, got.status);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_extremes();
    wait_drained();
    test_random_phase(0, 0, 200);
    test_random_phase(75, 0, 150);
    test_random_phase(0, 75, 150);
    wait_drained();
    test_random_phase(20, 20, 200);
    test_random_phase(0, 0, 80);
    wait_drained();
    repeat (LATENCY) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
